### src/plie_pkg.sv
// Shared constants, types and helpers for the posting-list intersection unit.
`timescale 1ns / 1ps

package plie_pkg;

    // Storage geometry
    localparam int MAX_LISTS    = 4;
    localparam int MAX_LIST_LEN = 1024;

    // Field widths fixed by the interface
    localparam int OP_W       = 2;
    localparam int LIST_NUM_W = 2;
    localparam int ID_W       = 32;
    localparam int CFG_W      = 3;

    // Derived widths
    localparam int LIST_BITS  = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int LIST_CNT_W = $clog2(MAX_LISTS + 1);
    localparam int POS_BITS   = $clog2(MAX_LIST_LEN);
    localparam int LEN_W      = $clog2(MAX_LIST_LEN + 1);
    localparam int STORE_DEPTH = (1 << LIST_BITS) * MAX_LIST_LEN;
    localparam int STORE_AW    = LIST_BITS + POS_BITS;
    localparam int CMP_W       = (LIST_CNT_W > CFG_W) ? LIST_CNT_W : CFG_W;

    // Command queue between front and back (power of two depth)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input word
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_PROBE = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_PROBE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [LIST_NUM_W-1:0]  list_num;
        logic [ID_W-1:0]        doc_id;
        logic                   last;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } back_state_t;

    // Count the set bits of a per-list hit vector
    function automatic logic [LIST_CNT_W-1:0] count_hits(input logic [MAX_LISTS-1:0] v);
        logic [LIST_CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < MAX_LISTS; i++) begin
            sum = sum + LIST_CNT_W'(v[i]);
        end
        return sum;
    endfunction

endpackage

### src/posting_list_intersect_by_element_unit.sv
// Top level of the posting-list intersection unit.
`timescale 1ns / 1ps

// Holds up to four posting lists of 32-bit document ids, 1024 ids each, in
// one RAM with a single read port. Input words: operation 0 clears all
// lists, 1 appends doc_id to list list_number (ignored once the list is
// full), 2 probes doc_id; each probe yields one result word with in_all set
// when the id appears in each of the first other_list_count lists. Clear and
// load words are executed from the queue while the back end is idle. A probe
// scans the first other_list_count lists (at most four) in turn, and the store
// gives one id per cycle while it reads a list. A two-word command queue keeps
// input flowing while a probe scans or a result waits. Write other_list_count
// only while the unit is idle.
module posting_list_intersect_by_element_unit import plie_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,   // [2:0] other_list_count
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ID_W-1:0]   s_tdata,    // [31:0] doc_id
    input  logic [3:0]        s_tuser,    // [1:0] operation, [3:2] list_number
    input  logic              s_tlast,
    // Result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ID_W-1:0]   m_tdata,    // [31:0] probe_id
    output logic              m_tuser,    // [0] in_all
    output logic              m_tlast
);

    logic [CFG_W-1:0] other_list_count_reg;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;

    assign cfg_ready = 1'b1;

    // Hold the match-count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            other_list_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            other_list_count_reg <= cfg_data;
        end
    end

    plie_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    plie_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .other_list_count (other_list_count_reg),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_pop          (cmd_pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

endmodule

### src/plie_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module plie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/plie_front.sv
// Front end: accepts input words, classifies them and queues commands.
`timescale 1ns / 1ps

module plie_front import plie_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ID_W-1:0]       s_tdata,   // [31:0] doc_id
    input  logic [3:0]            s_tuser,   // [1:0] operation, [3:2] list_number
    input  logic                  s_tlast,
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    input  logic                  cmd_pop
);

    cmd_t                queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    logic [OP_W-1:0]       op;
    logic [LIST_NUM_W-1:0] list_num;
    logic                  keep;
    logic                  push;
    logic                  pop;
    cmd_t                  new_cmd;

    assign op       = s_tuser[1:0];
    assign list_num = s_tuser[3:2];
    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));

    // Classify the word; drop unused codes and loads aimed past the last list
    always_comb begin
        keep            = 1'b0;
        new_cmd.kind    = CMD_CLEAR;
        new_cmd.list_num = list_num;
        new_cmd.doc_id  = s_tdata;
        new_cmd.last    = s_tlast;
        case (op)
            OP_CLEAR: begin
                keep         = 1'b1;
                new_cmd.kind = CMD_CLEAR;
            end
            OP_LOAD: begin
                keep         = ({1'b0, list_num} < (LIST_NUM_W + 1)'(MAX_LISTS)) ||
                               (MAX_LISTS > (1 << LIST_NUM_W));
                new_cmd.kind = CMD_LOAD;
            end
            OP_PROBE: begin
                keep         = 1'b1;
                new_cmd.kind = CMD_PROBE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push      = s_tvalid && s_tready && keep;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### src/plie_back.sv
// Back end: owns the list store, executes clear, load and probe commands.
`timescale 1ns / 1ps

module plie_back import plie_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CFG_W-1:0]  other_list_count,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ID_W-1:0]   m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    back_state_t            state_reg, state_next;
    logic [LEN_W-1:0]       len_reg [MAX_LISTS];
    logic [LEN_W-1:0]       len_next [MAX_LISTS];
    logic [LIST_CNT_W-1:0]  li_reg, li_next;
    logic [LEN_W-1:0]       pos_reg, pos_next;
    logic [LIST_CNT_W-1:0]  active_reg, active_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic                   last_reg, last_next;
    logic [MAX_LISTS-1:0]   hit_reg, hit_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [LIST_BITS-1:0]   rd_tag_reg, rd_tag_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic                   out_in_all_reg, out_in_all_next;
    logic                   out_last_reg, out_last_next;

    logic                   ram_wr_en;
    logic [STORE_AW-1:0]    ram_wr_addr;
    logic                   ram_rd_en;
    logic [STORE_AW-1:0]    ram_rd_addr;
    logic [ID_W-1:0]        ram_rd_data;

    logic [LIST_BITS-1:0]   load_list;
    logic [LIST_BITS-1:0]   scan_list;
    logic [LEN_W-1:0]       load_len;
    logic [LEN_W-1:0]       scan_len;
    logic                   out_free;
    logic [CMP_W-1:0]       cfg_wide;

    assign load_list = LIST_BITS'(cmd.list_num);
    assign scan_list = li_reg[LIST_BITS-1:0];
    assign load_len  = len_reg[load_list];
    assign scan_len  = len_reg[scan_list];
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_wide  = CMP_W'(other_list_count);

    assign ram_wr_addr = {load_list, load_len[POS_BITS-1:0]};
    assign ram_rd_addr = {scan_list, pos_reg[POS_BITS-1:0]};

    plie_ram #(
        .WIDTH (ID_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd.doc_id),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequence commands and the per-probe list scan
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        li_next         = li_reg;
        pos_next        = pos_reg;
        active_next     = active_reg;
        id_next         = id_reg;
        last_next       = last_reg;
        hit_next        = hit_reg;
        rd_pend_next    = 1'b0;
        rd_tag_next     = rd_tag_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_in_all_next = out_in_all_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;

        // Mark a list as holding the id when its returned word matches
        if (rd_pend_reg && (ram_rd_data == id_reg)) begin
            hit_next[rd_tag_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_CLEAR: begin
                            cmd_pop = 1'b1;
                            for (int i = 0; i < MAX_LISTS; i++) begin
                                len_next[i] = '0;
                            end
                        end
                        CMD_LOAD: begin
                            cmd_pop = 1'b1;
                            if (load_len < LEN_W'(MAX_LIST_LEN)) begin
                                ram_wr_en           = 1'b1;
                                len_next[load_list] = load_len + 1'b1;
                            end
                        end
                        CMD_PROBE: begin
                            if (out_free) begin
                                cmd_pop     = 1'b1;
                                id_next     = cmd.doc_id;
                                last_next   = cmd.last;
                                hit_next    = '0;
                                li_next     = '0;
                                pos_next    = '0;
                                active_next = (cfg_wide > CMP_W'(MAX_LISTS)) ?
                                              LIST_CNT_W'(MAX_LISTS) :
                                              LIST_CNT_W'(other_list_count);
                                state_next  = ST_SCAN;
                            end
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read a cycle; step to the next list at its end
                if (li_reg < active_reg) begin
                    if (pos_reg < scan_len) begin
                        ram_rd_en    = 1'b1;
                        rd_pend_next = 1'b1;
                        rd_tag_next  = scan_list;
                        pos_next     = pos_reg + 1'b1;
                    end else begin
                        li_next  = li_reg + 1'b1;
                        pos_next = '0;
                    end
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Wait for the last read, then post the result
                if (!rd_pend_reg) begin
                    out_valid_next  = 1'b1;
                    out_id_next     = id_reg;
                    out_last_next   = last_reg;
                    out_in_all_next = (CMP_W'(count_hits(hit_reg)) == cfg_wide);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= '0;
            for (int i = 0; i < MAX_LISTS; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        li_reg         <= li_next;
        pos_reg        <= pos_next;
        active_reg     <= active_next;
        id_reg         <= id_next;
        last_reg       <= last_next;
        rd_tag_reg     <= rd_tag_next;
        out_id_reg     <= out_id_next;
        out_in_all_reg <= out_in_all_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_in_all_reg;
    assign m_tlast  = out_last_reg;

    // Read data only returns for reads issued during a scan
    a_read_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> ($past(state_reg) == ST_SCAN))
        else $error("store read returned outside a scan");

    // Drain issues no reads, so nothing is pending in the next cycle
    a_drain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> !rd_pend_reg)
        else $error("read pending after drain cycle");

    // The result slot is free whenever a probe result is posted
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && !rd_pend_reg) |-> !out_valid_reg)
        else $error("probe result would overwrite a waiting word");

    // No more lists hit than are being scanned
    a_hits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (count_hits(hit_reg) <= active_reg))
        else $error("hit count exceeds active lists");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the posting-list intersection unit.
`timescale 1ns / 1ps

module tb_top;
    import plie_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_WORDS  = 580;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int POOL_SIZE     = 6;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_ZERO,
        CHECK_ONE
    } row_check_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [OP_W-1:0]       op;
        logic [LIST_NUM_W-1:0] list_num;
        logic [ID_W-1:0]       doc_id;
        logic                  is_last;
        logic [CFG_W-1:0]      cfg_value;
        row_check_t            check;
    } dir_row_t;

    typedef struct {
        logic [ID_W-1:0] probe_id;
        logic            in_all;
        logic            last_result;
    } probe_result_t;

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // empty lists, match count zero: every probe is in all lists
        '{ROW_WORD, OP_PROBE,  2'd0, 32'h0000_0000, 1'b0, 3'd0, CHECK_ONE},
        '{ROW_WORD, OP_PROBE,  2'd3, 32'hFFFF_FFFF, 1'b1, 3'd0, CHECK_ONE},
        // unused operation gives nothing
        '{ROW_WORD, OP_UNUSED, 2'd3, 32'hFFFF_FFFF, 1'b1, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_LOAD,   2'd0, 32'h0000_0000, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_LOAD,   2'd0, 32'hFFFF_FFFF, 1'b1, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_LOAD,   2'd1, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_MODEL},
        // duplicate id in one list counts once
        '{ROW_WORD, OP_LOAD,   2'd1, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_LOAD,   2'd2, 32'h0000_0005, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_LOAD,   2'd3, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_CFG,  OP_CLEAR,  2'd0, 32'h0000_0000, 1'b0, 3'd2, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd0, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd1, 32'h0000_0000, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd2, 32'h0000_0005, 1'b1, 3'd0, CHECK_MODEL},
        '{ROW_CFG,  OP_CLEAR,  2'd0, 32'h0000_0000, 1'b0, 3'd4, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd0, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_LOAD,   2'd2, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd0, 32'hFFFF_FFFF, 1'b1, 3'd0, CHECK_MODEL},
        // count beyond the stored lists can never be reached
        '{ROW_CFG,  OP_CLEAR,  2'd0, 32'h0000_0000, 1'b0, 3'd5, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd0, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_ZERO},
        '{ROW_CFG,  OP_CLEAR,  2'd0, 32'h0000_0000, 1'b0, 3'd7, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd0, 32'hFFFF_FFFF, 1'b1, 3'd0, CHECK_ZERO},
        // clear empties the lists but keeps the match count
        '{ROW_WORD, OP_CLEAR,  2'd2, 32'hFFFF_FFFF, 1'b1, 3'd0, CHECK_MODEL},
        '{ROW_CFG,  OP_CLEAR,  2'd0, 32'h0000_0000, 1'b0, 3'd1, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd0, 32'hFFFF_FFFF, 1'b0, 3'd0, CHECK_ZERO},
        '{ROW_CFG,  OP_CLEAR,  2'd0, 32'h0000_0000, 1'b0, 3'd0, CHECK_MODEL},
        '{ROW_WORD, OP_PROBE,  2'd0, 32'h0000_0000, 1'b1, 3'd0, CHECK_ONE}
    };

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [ID_W-1:0]  s_tdata;    // [31:0] doc_id
    logic [3:0]       s_tuser;    // [1:0] operation, [3:2] list_number
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [ID_W-1:0]  m_tdata;    // [31:0] probe_id
    logic             m_tuser;    // [0] in_all
    logic             m_tlast;

    // Own copy of the stored lists and the match count
    logic [ID_W-1:0]  shadow_lists [MAX_LISTS][MAX_LIST_LEN];
    int unsigned      shadow_len   [MAX_LISTS];
    logic [CFG_W-1:0] shadow_target;

    probe_result_t    pending_probes [$];
    int               error_count;
    int               results_seen;
    int               words_accepted;
    int               burst_left;

    posting_list_intersect_by_element_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Count the distinct active lists that hold the id; true when that equals the match count
    function automatic logic id_in_all(input logic [ID_W-1:0] id);
        int unsigned scan_lists;
        int unsigned hits;
        bit          found;
        scan_lists = (shadow_target > MAX_LISTS) ? MAX_LISTS : shadow_target;
        hits = 0;
        for (int j = 0; j < scan_lists; j++) begin
            found = 1'b0;
            for (int k = 0; k < shadow_len[j]; k++) begin
                if (shadow_lists[j][k] == id) found = 1'b1;
            end
            if (found) hits++;
        end
        return (hits == shadow_target);
    endfunction

    // Update the shadow lists for one accepted word, queue the probe result
    task automatic apply_word(input logic [OP_W-1:0] op, input logic [LIST_NUM_W-1:0] list_num,
                              input logic [ID_W-1:0] id, input logic is_last,
                              input bit use_fixed, input bit fixed_in_all);
        probe_result_t r;
        case (op)
            OP_CLEAR: begin
                for (int j = 0; j < MAX_LISTS; j++) shadow_len[j] = 0;
            end
            OP_LOAD: begin
                if (list_num < MAX_LISTS && shadow_len[list_num] < MAX_LIST_LEN) begin
                    shadow_lists[list_num][shadow_len[list_num]] = id;
                    shadow_len[list_num]++;
                end
            end
            OP_PROBE: begin
                r.probe_id    = id;
                r.in_all      = use_fixed ? fixed_in_all : id_in_all(id);
                r.last_result = is_last;
                pending_probes.insert(pending_probes.size(), r);
            end
            default: ;
        endcase
    endtask

    // Offer one word in bursts with random gaps, hold until accepted
    task automatic send_word(input logic [OP_W-1:0] op, input logic [LIST_NUM_W-1:0] list_num,
                             input logic [ID_W-1:0] id, input logic is_last,
                             input bit use_fixed, input bit fixed_in_all);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tuser  <= {list_num, op};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        apply_word(op, list_num, id, is_last, use_fixed, fixed_in_all);
        if (op != OP_UNUSED) words_accepted++;
    endtask

    // Drain the unit, then write the match count
    task automatic write_target(input logic [CFG_W-1:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_probes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        shadow_target = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stall the result side on a changing pattern, with one long hold-off
    initial begin : result_stall_gen
        int mode;
        int mode_left;
        bit hold_done;
        m_tready <= 1'b0;
        mode = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 30 && m_tvalid && s_tvalid) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (mode_left % 3 != 0);
            endcase
        end
    end

    // Compare each result word with the oldest queued probe
    always @(posedge aclk) begin : result_check
        probe_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_probes.size() == 0) begin
                note_mismatch($sformatf("result id %h with no probe pending", m_tdata));
            end else begin
                want = pending_probes.pop_front();
                if (m_tdata !== want.probe_id)
                    note_mismatch($sformatf("probe_id got %h want %h", m_tdata, want.probe_id));
                if (m_tuser !== want.in_all)
                    note_mismatch($sformatf("in_all for %h got %b want %b",
                                            want.probe_id, m_tuser, want.in_all));
                if (m_tlast !== want.last_result)
                    note_mismatch($sformatf("last_result for %h got %b want %b",
                                            want.probe_id, m_tlast, want.last_result));
            end
        end
    end

    initial begin : stimulus
        int              shape;
        int              random_goal;
        int              load_total;
        int              n_probes;
        int              j;
        int              load_left [MAX_LISTS];
        logic [ID_W-1:0] id_pool [POOL_SIZE];
        logic [ID_W-1:0] pick_id;
        logic [ID_W-1:0] base_id;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        error_count    = 0;
        results_seen   = 0;
        words_accepted = 0;
        burst_left     = 0;
        shadow_target  = '0;
        for (int k = 0; k < MAX_LISTS; k++) shadow_len[k] = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_target(DIRECTED[r].cfg_value);
            else
                send_word(DIRECTED[r].op, DIRECTED[r].list_num, DIRECTED[r].doc_id,
                          DIRECTED[r].is_last, DIRECTED[r].check != CHECK_MODEL,
                          DIRECTED[r].check == CHECK_ONE);
        end

        // Fill list 0 past its capacity; the extra loads must be dropped
        send_word(OP_CLEAR, 2'd0, 32'h0, 1'b0, 1'b0, 1'b0);
        write_target(3'd1);
        base_id = $urandom;
        for (int k = 0; k < MAX_LIST_LEN + 8; k++)
            send_word(OP_LOAD, 2'd0, base_id + k, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
        send_word(OP_LOAD, 2'd1, base_id, 1'b0, 1'b0, 1'b0);
        send_word(OP_PROBE, 2'd0, base_id + MAX_LIST_LEN - 1, 1'b0, 1'b0, 1'b0);
        send_word(OP_PROBE, 2'd0, base_id + MAX_LIST_LEN, 1'b0, 1'b1, 1'b0);
        send_word(OP_PROBE, 2'd0, base_id, 1'b1, 1'b0, 1'b0);
        write_target(3'd2);
        send_word(OP_PROBE, 2'd1, base_id, 1'b0, 1'b0, 1'b0);
        send_word(OP_PROBE, 2'd2, base_id + 1, 1'b1, 1'b0, 1'b0);

        // Random queries: mostly clear, load, probe; some noise and broken runs
        random_goal = words_accepted + RANDOM_WORDS;
        while (words_accepted < random_goal) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                repeat ($urandom_range(4, 12))
                    send_word(OP_W'($urandom_range(0, 3)), LIST_NUM_W'($urandom_range(0, 3)),
                              $urandom, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
            end else begin
                if (shape != 1)
                    send_word(OP_CLEAR, LIST_NUM_W'($urandom_range(0, 3)), $urandom,
                              1'($urandom_range(0, 1)), 1'b0, 1'b0);
                if (shape != 1 || $urandom_range(0, 1) == 1)
                    write_target(CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                                    : $urandom_range(0, 4)));
                for (int p = 0; p < POOL_SIZE; p++) begin
                    if ($urandom_range(0, 15) == 0)
                        id_pool[p] = ($urandom_range(0, 1) == 1) ? '1 : '0;
                    else
                        id_pool[p] = $urandom;
                end
                load_total = 0;
                for (int k = 0; k < MAX_LISTS; k++) begin
                    load_left[k] = (k < shadow_target) ? $urandom_range(0, 12)
                                                       : $urandom_range(0, 3);
                    load_total += load_left[k];
                end
                // Interleave loads over the lists
                while (load_total > 0) begin
                    j = $urandom_range(0, MAX_LISTS - 1);
                    if (load_left[j] > 0) begin
                        load_left[j]--;
                        load_total--;
                        pick_id = ($urandom_range(0, 3) != 0)
                                  ? id_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
                        send_word(OP_LOAD, LIST_NUM_W'(j), pick_id, 1'($urandom_range(0, 1)),
                                  1'b0, 1'b0);
                    end
                end
                n_probes = $urandom_range(1, 16);
                for (int p = 0; p < n_probes; p++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_word(OP_UNUSED, LIST_NUM_W'($urandom_range(0, 3)), $urandom,
                                  1'($urandom_range(0, 1)), 1'b0, 1'b0);
                    pick_id = ($urandom_range(0, 4) != 0)
                              ? id_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
                    send_word(OP_PROBE, LIST_NUM_W'($urandom_range(0, 3)), pick_id,
                              (shape == 1) ? 1'($urandom_range(0, 1)) : (p == n_probes - 1),
                              1'b0, 1'b0);
                end
            end
        end

        // Drop valid, wait for the last results, then settle
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_probes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
src/plie_pkg.sv
src/plie_ram.sv
src/plie_front.sv
src/plie_back.sv
src/posting_list_intersect_by_element_unit.sv
tb/sv/tb_top.sv
